// File: rtl/integrate_fire_burst_neuron_core_defines.svh
// assertion macros shared by the rtl of the integrate-and-fire-or-burst neuron core
// no dependencies; included by files that carry concurrent checks
`ifndef INTEGRATE_FIRE_BURST_NEURON_CORE_DEFINES_SVH
`define INTEGRATE_FIRE_BURST_NEURON_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define IFB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define IFB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/ifb_pkg.sv
// constants and types of the integrate-and-fire-or-burst neuron core
// no dependencies; used by the core and the testbench
`default_nettype none

package ifb_pkg;

  // gate time constants, Q1.15 per step
  localparam logic [32:0] H_DECAY = 33'd164;
  localparam logic [32:0] H_RISE  = 33'd33;
  localparam logic [15:0] H_ONE   = 16'h8000;

  localparam int CFG_INDEX_W = 4;
  localparam int ACC_W       = 52;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LEAK_FACTOR       = 4'd0,
    REG_CURRENT_GAIN      = 4'd1,
    REG_BIAS_DRIVE        = 4'd2,
    REG_BURST_GAIN        = 4'd3,
    REG_THRESHOLD_VOLTAGE = 4'd4,
    REG_RESET_VOLTAGE     = 4'd5,
    REG_BURST_VOLTAGE     = 4'd6,
    REG_REFRACTORY_STEPS  = 4'd7
  } cfg_reg_t;

  localparam logic        [15:0] LEAK_FACTOR_RST       = 16'd32603;
  localparam logic signed [31:0] CURRENT_GAIN_RST      = 32'sd65536;
  localparam logic signed [31:0] THRESHOLD_VOLTAGE_RST = -32'sd587203;
  localparam logic signed [31:0] RESET_VOLTAGE_RST     = -32'sd838861;
  localparam logic signed [31:0] BURST_VOLTAGE_RST     = -32'sd1006633;
  localparam logic        [15:0] REFRACTORY_STEPS_RST  = 16'd30;
  localparam logic signed [31:0] V_INIT                = -32'sd1090519;

  localparam logic signed [63:0] ROUND_HALF = 64'sd16384;
  localparam logic signed [63:0] TERM_LIMIT = 64'sh0000_0100_0000_0000;
  localparam logic signed [ACC_W-1:0] SAT_MAX = 52'sd2147483647;
  localparam logic signed [ACC_W-1:0] SAT_MIN = -52'sd2147483648;

endpackage

`default_nettype wire

// File: rtl/ifb_channels.sv
// valid/ready channel interfaces of the integrate-and-fire-or-burst neuron core
// no dependencies
`default_nettype none

interface ifb_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] synaptic_current;
  modport source (output valid, output synaptic_current, input ready);
  modport sink   (input valid, input synaptic_current, output ready);
endinterface

interface ifb_out_if;
  logic               valid;
  logic               ready;
  logic               fired;
  logic signed [31:0] membrane_voltage;
  modport source (output valid, output fired, output membrane_voltage, input ready);
  modport sink   (input valid, input fired, input membrane_voltage, output ready);
endinterface

interface ifb_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/integrate_fire_burst_neuron_core.sv
// integrate-and-fire-or-burst neuron: one time step per input beat
// depends on ifb_pkg, the channel interfaces in ifb_channels.sv and the macro header
//
// usage:
//   in_ch  : one beat per time step, the summed synaptic current
//   out_ch : one beat per time step, fired flag and membrane voltage after the step
//   cfg_ch : register writes (index 0..7), always ready; write only while idle,
//            unknown indexes are dropped
// one 33x33 signed multiplier with a registered product is shared by the gate
// update, the leak, the current term and the burst term under a small sequencer.
// a refractory or firing step runs S_GATE, S_HUPD and S_DONE; an integrating
// step runs S_LEAK, S_CUR and S_BURST between S_HUPD and S_DONE; the input is
// not ready meanwhile, so a new step is taken only after the last one is done.
// results sit in an output register: a new step is accepted while the last
// result waits; a stalled receiver holds the next result in the final state
// and the core takes no further step until it drains.
// reset (rst, synchronous) loads register defaults, voltage -0.065 V, gate 0,
// not refractory, and empties the output register.
`default_nettype none

module integrate_fire_burst_neuron_core (
  input  wire logic clk,
  input  wire logic rst,
  ifb_in_if.sink    in_ch,
  ifb_out_if.source out_ch,
  ifb_cfg_if.sink   cfg_ch
);
  import ifb_pkg::*;

`include "integrate_fire_burst_neuron_core_defines.svh"

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_GATE  = 7'b0000010,
    S_HUPD  = 7'b0000100,
    S_LEAK  = 7'b0001000,
    S_CUR   = 7'b0010000,
    S_BURST = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state;

  // configuration
  logic        [15:0] leak_factor;
  logic signed [31:0] current_gain;
  logic signed [31:0] bias_drive;
  logic signed [31:0] burst_gain;
  logic signed [31:0] threshold_voltage;
  logic signed [31:0] reset_voltage;
  logic signed [31:0] burst_voltage;
  logic        [15:0] refractory_steps;

  // neuron state
  logic signed [31:0] voltage;
  logic        [15:0] burst_gate;
  logic        [15:0] refractory_count;

  // step working registers
  logic signed [31:0]      cur;
  logic                    above;
  logic                    fired_q;
  logic signed [63:0]      prod;
  logic signed [ACC_W-1:0] acc;

  // output register
  logic               out_valid;
  logic               out_fired;
  logic signed [31:0] out_voltage;

  logic signed [32:0] op_a;
  logic signed [32:0] op_b;
  logic signed [65:0] mul_full;

  logic signed [63:0]      prod_rnd;
  logic        [17:0]      gate_step;
  logic signed [18:0]      h_calc;
  logic        [15:0]      h_next;
  logic signed [63:0]      cur_term;
  logic signed [ACC_W-1:0] sum_next;
  logic signed [31:0]      sat_next;
  logic                    in_beat;

  assign in_ch.ready  = (state == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_beat      = in_ch.valid && in_ch.ready;

  assign out_ch.valid            = out_valid;
  assign out_ch.fired            = out_fired;
  assign out_ch.membrane_voltage = out_voltage;

  // shared multiplier operand select
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state)
      S_GATE: begin
        op_a = above ? H_DECAY : H_RISE;
        op_b = above ? {17'b0, burst_gate} : {17'b0, H_ONE - burst_gate};
      end
      S_HUPD: begin
        op_a = {17'b0, leak_factor};
        op_b = {voltage[31], voltage};
      end
      S_LEAK: begin
        op_a = {current_gain[31], current_gain};
        op_b = {cur[31], cur};
      end
      S_CUR: begin
        op_a = {burst_gain[31], burst_gain};
        op_b = {17'b0, burst_gate};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign mul_full = op_a * op_b;

  // round half up by 15 bits; arithmetic shift floors negative values
  assign prod_rnd = (prod + ROUND_HALF) >>> 15;

  // gate product is never negative
  assign gate_step = prod_rnd[17:0];

  always_comb begin
    if (above) begin
      h_calc = $signed({3'b0, burst_gate}) - $signed({1'b0, gate_step});
    end else begin
      h_calc = $signed({3'b0, burst_gate}) + $signed({1'b0, gate_step});
    end
    if (h_calc < 19'sd0) begin
      h_next = '0;
    end else if (h_calc > $signed({3'b0, H_ONE})) begin
      h_next = H_ONE;
    end else begin
      h_next = h_calc[15:0];
    end
  end

  // current term clamped to +-2^40 before the Q16.16 to Q8.24 scale
  always_comb begin
    if (prod > TERM_LIMIT) begin
      cur_term = TERM_LIMIT;
    end else if (prod < -TERM_LIMIT) begin
      cur_term = -TERM_LIMIT;
    end else begin
      cur_term = prod;
    end
  end

  always_comb begin
    sum_next = acc + (above ? prod_rnd[ACC_W-1:0] : '0);
    if (sum_next > SAT_MAX) begin
      sat_next = SAT_MAX[31:0];
    end else if (sum_next < SAT_MIN) begin
      sat_next = SAT_MIN[31:0];
    end else begin
      sat_next = sum_next[31:0];
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_full[63:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      leak_factor       <= LEAK_FACTOR_RST;
      current_gain      <= CURRENT_GAIN_RST;
      bias_drive        <= '0;
      burst_gain        <= '0;
      threshold_voltage <= THRESHOLD_VOLTAGE_RST;
      reset_voltage     <= RESET_VOLTAGE_RST;
      burst_voltage     <= BURST_VOLTAGE_RST;
      refractory_steps  <= REFRACTORY_STEPS_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        REG_LEAK_FACTOR:       leak_factor       <= cfg_ch.data[15:0];
        REG_CURRENT_GAIN:      current_gain      <= cfg_ch.data;
        REG_BIAS_DRIVE:        bias_drive        <= cfg_ch.data;
        REG_BURST_GAIN:        burst_gain        <= cfg_ch.data;
        REG_THRESHOLD_VOLTAGE: threshold_voltage <= cfg_ch.data;
        REG_RESET_VOLTAGE:     reset_voltage     <= cfg_ch.data;
        REG_BURST_VOLTAGE:     burst_voltage     <= cfg_ch.data;
        REG_REFRACTORY_STEPS:  refractory_steps  <= cfg_ch.data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      voltage          <= V_INIT;
      burst_gate       <= '0;
      refractory_count <= '0;
      out_valid        <= 1'b0;
    end else begin
      // the final state reloads the output register itself
      if (out_valid && out_ch.ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_beat) begin
            cur   <= in_ch.synaptic_current;
            above <= voltage > burst_voltage;
            state <= S_GATE;
          end
        end
        S_GATE: begin
          state <= S_HUPD;
        end
        S_HUPD: begin
          burst_gate <= h_next;
          if (refractory_count != 16'd0) begin
            refractory_count <= refractory_count - 16'd1;
            fired_q          <= 1'b0;
            state            <= S_DONE;
          end else if (voltage >= threshold_voltage) begin
            refractory_count <= refractory_steps;
            voltage          <= reset_voltage;
            fired_q          <= 1'b1;
            state            <= S_DONE;
          end else begin
            fired_q <= 1'b0;
            state   <= S_LEAK;
          end
        end
        S_LEAK: begin
          acc   <= prod_rnd[ACC_W-1:0] + {{(ACC_W-32){bias_drive[31]}}, bias_drive};
          state <= S_CUR;
        end
        S_CUR: begin
          acc   <= acc + {cur_term[ACC_W-9:0], 8'b0};
          state <= S_BURST;
        end
        S_BURST: begin
          voltage <= sat_next;
          state   <= S_DONE;
        end
        S_DONE: begin
          // wait for the output register to free up
          if (!out_valid || out_ch.ready) begin
            out_valid   <= 1'b1;
            out_fired   <= fired_q;
            out_voltage <= voltage;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `IFB_ASSERT_NEXT(a_accept_starts_step, clk, rst, in_beat, state == S_GATE,
    "accepted beat did not start a step")
  `IFB_ASSERT_NOW(a_gate_in_range, clk, rst, 1'b1, burst_gate <= H_ONE,
    "burst gate above one")
  `IFB_ASSERT_NEXT(a_refractory_skips_integrate, clk, rst,
    (state == S_HUPD) && (refractory_count != 16'd0),
    (state == S_DONE) && (voltage == $past(voltage)),
    "refractory step changed the voltage")
  `IFB_ASSERT_NOW(a_fire_loads_counter, clk, rst,
    (state == S_IDLE) && out_valid && out_fired,
    (refractory_count == refractory_steps) && (out_voltage == voltage),
    "spike result disagrees with neuron state")

endmodule

`default_nettype wire

// File: dv/tb_integrate_fire_burst_neuron_core.sv
// self-checking testbench of the integrate-and-fire-or-burst neuron core
// depends on ifb_pkg, the channel interfaces and the core; predicts every step in-bench
// directed register and corner tests, then random steps under three idling patterns
`default_nettype none

module tb_integrate_fire_burst_neuron_core;
  import ifb_pkg::*;

  localparam int GATE_DECAY    = 164;
  localparam int GATE_RISE     = 33;
  localparam int GATE_ONE      = 32768;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 10;

  localparam logic signed [31:0] REST_VOLTAGE = -32'sd1090519;
  localparam logic signed [63:0] HALF_LSB     = 64'sd16384;
  localparam logic signed [63:0] CUR_TERM_MAX = 64'sh0000_0100_0000_0000;
  localparam logic signed [63:0] VOLT_MAX     = 64'sd2147483647;
  localparam logic signed [63:0] VOLT_MIN     = -64'sd2147483648;

  // indexes past the register file, dropped by the core
  localparam logic [3:0] REG_SPARE_LO = 4'd8;
  localparam logic [3:0] REG_SPARE_HI = 4'd15;

  typedef struct packed {
    logic               fired;
    logic signed [31:0] voltage;
  } step_result_t;

  logic clk = 1'b0;
  logic rst;

  ifb_in_if  in_if();
  ifb_out_if out_if();
  ifb_cfg_if cfg_if();

  integrate_fire_burst_neuron_core u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predicted registers
  logic        [15:0] reg_leak;
  logic signed [31:0] reg_gain;
  logic signed [31:0] reg_bias;
  logic signed [31:0] reg_burst_gain;
  logic signed [31:0] reg_threshold;
  logic signed [31:0] reg_reset_v;
  logic signed [31:0] reg_burst_v;
  logic        [15:0] reg_refr;

  // predicted neuron state
  logic signed [31:0] v_mem;
  logic        [15:0] h_gate;
  logic        [15:0] refr_left;

  step_result_t pending_steps[$];
  int           mismatches;
  int           stall_cycles = 0;
  int           send_idle_pct;
  int           recv_idle_pct;
  bit           wild_mode;
  int           cur_span;

  function automatic void apply_reg(input logic [3:0] idx, input logic [31:0] val);
    case (idx)
      REG_LEAK_FACTOR:       reg_leak       = val[15:0];
      REG_CURRENT_GAIN:      reg_gain       = val;
      REG_BIAS_DRIVE:        reg_bias       = val;
      REG_BURST_GAIN:        reg_burst_gain = val;
      REG_THRESHOLD_VOLTAGE: reg_threshold  = val;
      REG_RESET_VOLTAGE:     reg_reset_v    = val;
      REG_BURST_VOLTAGE:     reg_burst_v    = val;
      REG_REFRACTORY_STEPS:  reg_refr       = val[15:0];
      default: ;
    endcase
  endfunction

  function automatic void predict_step(input logic signed [31:0] cur,
                                       output step_result_t res);
    logic              above;
    int                h;
    logic signed [63:0] acc;
    logic signed [63:0] prod;
    logic signed [63:0] lf;
    logic signed [63:0] vv;
    logic signed [63:0] gg;
    logic signed [63:0] cc;
    logic signed [63:0] bb;
    logic signed [63:0] bg;
    logic signed [63:0] hh;
    above = (v_mem > reg_burst_v);
    // gate moves on the voltage held before the step
    h = h_gate;
    if (above) begin
      h = h - ((GATE_DECAY * h + 16384) >>> 15);
    end else begin
      h = h + ((GATE_RISE * (GATE_ONE - h) + 16384) >>> 15);
    end
    if (h < 0) h = 0;
    if (h > GATE_ONE) h = GATE_ONE;
    h_gate = 16'(h);
    res.fired = 1'b0;
    if (refr_left != 16'd0) begin
      refr_left = refr_left - 16'd1;
    end else if (v_mem >= reg_threshold) begin
      res.fired = 1'b1;
      refr_left = reg_refr;
      v_mem     = reg_reset_v;
    end else begin
      lf   = {48'd0, reg_leak};
      vv   = v_mem;
      acc  = (lf * vv + HALF_LSB) >>> 15;
      gg   = reg_gain;
      cc   = cur;
      prod = gg * cc;
      if (prod > CUR_TERM_MAX) prod = CUR_TERM_MAX;
      if (prod < -CUR_TERM_MAX) prod = -CUR_TERM_MAX;
      acc  = acc + (prod <<< 8);
      bb   = reg_bias;
      acc  = acc + bb;
      if (above) begin
        bg  = reg_burst_gain;
        hh  = {48'd0, h_gate};
        acc = acc + ((bg * hh + HALF_LSB) >>> 15);
      end
      if (acc > VOLT_MAX) acc = VOLT_MAX;
      if (acc < VOLT_MIN) acc = VOLT_MIN;
      v_mem = acc[31:0];
    end
    res.voltage = v_mem;
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(4))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [31:0] draw_current();
    int r;
    r = $urandom_range(99);
    if (wild_mode) begin
      if (r < 70) return $urandom;
      return pick_word();
    end
    if (r < 85) return int'($urandom_range(0, 3 * cur_span)) - cur_span;
    if (r < 95) return $urandom;
    return pick_word();
  endfunction

  task automatic send_step(input logic signed [31:0] cur);
    step_result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid            <= 1'b1;
    in_if.synaptic_current <= cur;
    do @(posedge clk); while (!in_if.ready);
    predict_step(cur, res);
    pending_steps.push_back(res);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending_steps.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [3:0] idx, input logic [31:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    apply_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic randomize_config();
    int gain;
    wild_mode = ($urandom_range(3) == 0);
    if (wild_mode) begin
      write_reg(REG_LEAK_FACTOR, $urandom_range(0, 65535));
      write_reg(REG_CURRENT_GAIN, pick_word());
      write_reg(REG_BIAS_DRIVE, pick_word());
      write_reg(REG_BURST_GAIN, pick_word());
      write_reg(REG_THRESHOLD_VOLTAGE, pick_word());
      write_reg(REG_RESET_VOLTAGE, pick_word());
      write_reg(REG_BURST_VOLTAGE, pick_word());
      write_reg(REG_REFRACTORY_STEPS, $urandom_range(0, 20));
    end else begin
      gain     = $urandom_range(1, 64);
      cur_span = 60000 / (gain * 256) + 1;
      write_reg(REG_LEAK_FACTOR, $urandom_range(30000, 32767));
      write_reg(REG_CURRENT_GAIN, gain);
      write_reg(REG_BIAS_DRIVE, int'($urandom_range(0, 60000)) - 30000);
      write_reg(REG_BURST_GAIN, int'($urandom_range(0, 400000)) - 200000);
      write_reg(REG_THRESHOLD_VOLTAGE, -587203 + int'($urandom_range(0, 400000)) - 200000);
      write_reg(REG_RESET_VOLTAGE, -838861 + int'($urandom_range(0, 200000)) - 100000);
      write_reg(REG_BURST_VOLTAGE, -1006633 + int'($urandom_range(0, 200000)) - 100000);
      write_reg(REG_REFRACTORY_STEPS, $urandom_range(0, 6));
    end
    if ($urandom_range(3) == 0) write_reg(REG_SPARE_LO + 4'($urandom_range(0, 7)), $urandom);
  endtask

  task automatic test_default_registers();
    send_step(32'sd0);
    send_step(-32'sd1);
    drain();
  endtask

  task automatic test_refractory_hold();
    write_reg(REG_REFRACTORY_STEPS, 32'd2);
    send_step(32'sh7fff_ffff);
    send_step(32'sd0);
    send_step(32'sd0);
    send_step(32'sd0);
    send_step(32'sd0);
    drain();
  endtask

  // reset voltage above threshold with no hold: fires on back-to-back steps
  task automatic test_zero_refractory();
    write_reg(REG_REFRACTORY_STEPS, 32'd0);
    write_reg(REG_RESET_VOLTAGE, 32'h7fff_ffff);
    send_step(32'sh7fff_ffff);
    send_step(32'sd0);
    send_step(32'sd0);
    drain();
  endtask

  task automatic test_current_clamp();
    write_reg(REG_THRESHOLD_VOLTAGE, 32'h7fff_ffff);
    write_reg(REG_RESET_VOLTAGE, 32'h8000_0000);
    write_reg(REG_CURRENT_GAIN, 32'h7fff_ffff);
    send_step(32'sh8000_0000);
    send_step(32'sh8000_0000);
    send_step(32'sh7fff_ffff);
    send_step(32'sd0);
    drain();
    write_reg(REG_CURRENT_GAIN, 32'h8000_0000);
    send_step(-32'sd1);
    send_step(32'sd0);
    send_step(32'sh8000_0000);
    drain();
  endtask

  task automatic test_leak_extremes();
    write_reg(REG_CURRENT_GAIN, 32'd1);
    write_reg(REG_LEAK_FACTOR, 32'd0);
    write_reg(REG_RESET_VOLTAGE, -32'sd838861);
    send_step(32'sd1000);
    send_step(32'sd1000);
    drain();
    write_reg(REG_LEAK_FACTOR, 32'd65535);
    send_step(32'sd0);
    drain();
    write_reg(REG_LEAK_FACTOR, 32'd32768);
    send_step(-32'sd3);
    drain();
  endtask

  task automatic test_burst_term();
    write_reg(REG_CURRENT_GAIN, 32'd0);
    write_reg(REG_BIAS_DRIVE, 32'd0);
    write_reg(REG_BURST_VOLTAGE, 32'h8000_0000);
    write_reg(REG_BURST_GAIN, 32'h7fff_ffff);
    send_step(32'sd0);
    send_step(32'sd0);
    drain();
    write_reg(REG_BURST_GAIN, 32'h8000_0000);
    write_reg(REG_BIAS_DRIVE, 32'h7fff_ffff);
    send_step(32'sd0);
    drain();
    // gate only rises when nothing is above the burst voltage
    write_reg(REG_BURST_VOLTAGE, 32'h7fff_ffff);
    write_reg(REG_BIAS_DRIVE, 32'h8000_0000);
    send_step(32'sd0);
    drain();
  endtask

  task automatic test_ignored_index();
    write_reg(REG_SPARE_LO, 32'hffff_ffff);
    write_reg(REG_SPARE_HI, 32'hffff_ffff);
    send_step(32'sd0);
    drain();
  endtask

  task automatic test_random_phase(input int n_steps, input int s_pct, input int r_pct);
    int sent;
    int chunk;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    sent = 0;
    while (sent < n_steps) begin
      randomize_config();
      chunk = $urandom_range(60, 120);
      for (int i = 0; i < chunk && sent < n_steps; i++) begin
        send_step(draw_current());
        sent++;
      end
      drain();
    end
  endtask

  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    step_result_t want;
    if (!rst && out_if.valid && out_if.ready) begin
      if (pending_steps.size() == 0) begin
        $display("%0t unexpected beat: fired %0b voltage %0d", $time,
                 out_if.fired, out_if.membrane_voltage);
        mismatches++;
      end else begin
        want = pending_steps.pop_front();
        if (out_if.fired !== want.fired) begin
          $display("%0t fired mismatch: expected %0b actual %0b", $time,
                   want.fired, out_if.fired);
          mismatches++;
        end
        if (out_if.membrane_voltage !== want.voltage) begin
          $display("%0t membrane_voltage mismatch: expected %0d actual %0d", $time,
                   want.voltage, out_if.membrane_voltage);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t watchdog: no beat for %0d cycles", $time, STALL_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst                    <= 1'b1;
    in_if.valid            <= 1'b0;
    in_if.synaptic_current <= 32'sd0;
    cfg_if.valid           <= 1'b0;
    cfg_if.index           <= REG_LEAK_FACTOR;
    cfg_if.data            <= 32'd0;
    mismatches     = 0;
    send_idle_pct  = 12;
    recv_idle_pct  = 50;
    wild_mode      = 1'b0;
    cur_span       = 1;
    reg_leak       = 16'd32603;
    reg_gain       = 32'sd65536;
    reg_bias       = 32'sd0;
    reg_burst_gain = 32'sd0;
    reg_threshold  = -32'sd587203;
    reg_reset_v    = -32'sd838861;
    reg_burst_v    = -32'sd1006633;
    reg_refr       = 16'd30;
    v_mem          = REST_VOLTAGE;
    h_gate         = 16'd0;
    refr_left      = 16'd0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_default_registers();
    test_refractory_hold();
    test_zero_refractory();
    test_current_clamp();
    test_leak_extremes();
    test_burst_term();
    test_ignored_index();
    test_random_phase(340, 12, 50);
    test_random_phase(340, 50, 12);
    test_random_phase(340, 0, 0);

    drain();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
